// File: rtl/core/ars_pkg.sv
package ars_pkg;

  // Largest group handled; larger group sizes saturate to it
  localparam int MaxRanks = 1024;

  localparam int DataW = 32;  // element counts and offsets
  localparam int SizeW = 11;  // group size register
  localparam int RankW = 10;  // rank and peer
  localparam int IdxW  = 12;  // block index, up to MaxRanks inclusive
  localparam int StepW = 4;   // exchange step number, up to log2(MaxRanks)
  localparam int CodeW = 8;   // type and operation codes

  typedef enum logic [2:0] {
    ACT_COPY   = 3'd0,
    ACT_SEND   = 3'd1,
    ACT_RECV   = 3'd2,
    ACT_REDUCE = 3'd3,
    ACT_DONE   = 3'd4
  } action_t;

  typedef enum logic [0:0] {
    CFG_GROUP_SIZE = 1'b0,
    CFG_MY_RANK    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PLAN,
    ST_STEP,
    ST_OFF,
    ST_CNT
  } state_t;

  typedef enum logic [3:0] {
    PH_ERR,
    PH_COPY,
    PH_FIN_SEND,
    PH_FIN_RECV,
    PH_FIN_RED,
    PH_RS_RECV,
    PH_RS_SEND,
    PH_RS_RED,
    PH_AG_RECV,
    PH_AG_SEND,
    PH_FOUT,
    PH_DONE
  } phase_t;

  // Fields of one schedule entry that do not come out of the multiplier
  typedef struct packed {
    action_t          action;
    logic [RankW-1:0] peer;
    logic             bsel;
    logic             bar;
    logic             err;
    logic             last;
    logic [CodeW-1:0] dtype;
    logic [CodeW-1:0] op;
  } entry_t;

  // Operands of the shared multiply-add unit: mult * q (+ r)
  typedef struct packed {
    logic [IdxW-1:0] mult;
    logic            add_rem;
  } mul_op_t;

  typedef struct packed {
    logic   unit_en;
    logic   entry_done;
    entry_t entry;
  } seq_ctl_t;

endpackage

// File: rtl/core/ars_mul.sv
module ars_mul (
  input  logic                       clk,
  input  logic                       en,
  input  ars_pkg::mul_op_t           op,
  input  logic [ars_pkg::DataW-1:0]  blk_q,
  input  logic [ars_pkg::DataW-1:0]  blk_r,
  output logic [ars_pkg::DataW-1:0]  res
);
  import ars_pkg::*;

  logic [DataW+IdxW-1:0] prod;
  logic [DataW-1:0]      sum;
  logic [DataW-1:0]      res_r;

  // Only the low word matters: offsets and counts wrap at 32 bits
  assign prod = {{IdxW{1'b0}}, blk_q} * {{DataW{1'b0}}, op.mult};
  assign sum  = prod[DataW-1:0] + (op.add_rem ? blk_r : '0);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= sum;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/core/ars_seq.sv
module ars_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ars_pkg::DataW-1:0]  elem_total,
  input  logic                       in_place,
  input  logic [ars_pkg::CodeW-1:0]  dtype_id,
  input  logic [ars_pkg::CodeW-1:0]  op_id,
  input  logic [ars_pkg::SizeW-1:0]  group_size,
  input  logic [ars_pkg::RankW-1:0]  my_rank,
  input  logic                       advance,
  output ars_pkg::seq_ctl_t          ctl,
  output ars_pkg::mul_op_t           mul_op,
  output logic [ars_pkg::DataW-1:0]  blk_q,
  output logic [ars_pkg::DataW-1:0]  blk_r
);
  import ars_pkg::*;

  function automatic phase_t core_start(logic act, logic [StepW-1:0] lg, logic fold);
    phase_t ph;
    if (act && lg != '0) ph = PH_RS_RECV;
    else if (fold)       ph = PH_FOUT;
    else                 ph = PH_DONE;
    return ph;
  endfunction

  function automatic phase_t after_copy(logic fold, logic odd, logic act,
                                        logic [StepW-1:0] lg);
    phase_t ph;
    if (fold) ph = odd ? PH_FIN_RECV : PH_FIN_SEND;
    else      ph = core_start(act, lg, fold);
    return ph;
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nx, plan_phase;

  // request
  logic [DataW-1:0] cnt_r;
  logic             inpl_r;
  logic [CodeW-1:0] dtype_r, op_r;

  // group geometry
  logic [SizeW-1:0] size_c;
  logic [StepW-1:0] lg_c, lg_r;
  logic [IdxW-1:0]  pof2_c, pof2_r;
  logic [RankW-1:0] rank_c, rank_r, rem_c, rem_r;
  logic             fold_c, fold_r, active_c, active_r, err_c;
  logic [RankW-1:0] newrank_c, newrank_r;
  logic [DataW-1:0] q_r, r_r;

  // exchange step bookkeeping
  logic [StepW-1:0] k_r;
  logic [IdxW-1:0]  send_r, recv_r, last_r;
  logic [IdxW-1:0]  sa_r, sb_r, ra_r, rb_r;
  logic [RankW-1:0] dst_r, mask_c, newdst_c, dst_c;
  logic [IdxW-1:0]  half_c, send_h, recv_h, send_m, last_ag;
  logic             up_c, rs_more, is_last;

  // current entry
  entry_t          entry_c;
  logic [IdxW-1:0] off_idx, cnt_a, cnt_b;

  // --- geometry from the configuration ---
  always_comb begin
    if (group_size == '0)                    size_c = SizeW'(1);
    else if (group_size > SizeW'(MaxRanks))  size_c = SizeW'(MaxRanks);
    else                                     size_c = group_size;
    lg_c = '0;
    for (int i = 0; i < SizeW; i++) begin
      if (size_c[i]) lg_c = StepW'(i);
    end
  end

  assign pof2_c = IdxW'(1) << lg_c;
  assign rank_c = ({1'b0, my_rank} >= size_c) ? RankW'(size_c - SizeW'(1)) : my_rank;
  assign rem_c  = RankW'(size_c - SizeW'(pof2_c));

  assign fold_c    = {1'b0, rank_r} < {rem_r, 1'b0};
  assign newrank_c = fold_c ? (rank_r >> 1) : (rank_r - rem_r);
  assign active_c  = !(fold_c && !rank_r[0]);
  assign err_c     = cnt_r < DataW'(pof2_r);

  assign plan_phase = err_c ? PH_ERR :
                      (!inpl_r ? PH_COPY : after_copy(fold_c, rank_r[0], active_c, lg_r));

  // --- step arithmetic ---
  assign mask_c   = RankW'(1) << k_r;
  assign half_c   = pof2_r >> (k_r + StepW'(1));
  assign newdst_c = newrank_r ^ mask_c;
  assign dst_c    = (newdst_c < rem_r) ? {newdst_c[RankW-2:0], 1'b1} : (newdst_c + rem_r);
  assign up_c     = (newrank_r & mask_c) == '0;
  assign send_h   = send_r + half_c;
  assign recv_h   = recv_r + half_c;
  assign send_m   = send_r - half_c;
  assign last_ag  = (k_r != lg_r - StepW'(1)) ? (last_r + half_c) : last_r;
  assign rs_more  = (k_r + StepW'(1)) < lg_r;

  // --- entry descriptor ---
  always_comb begin
    entry_c        = '0;
    entry_c.action = ACT_DONE;
    entry_c.dtype  = dtype_r;
    entry_c.op     = op_r;
    off_idx        = '0;
    cnt_a          = '0;
    cnt_b          = pof2_r;
    unique case (phase_r)
      PH_ERR: begin
        entry_c.err  = 1'b1;
        entry_c.last = 1'b1;
        cnt_b        = '0;
      end
      PH_COPY: begin
        entry_c.action = ACT_COPY;
        entry_c.bar    = 1'b1;
      end
      PH_FIN_SEND: begin
        entry_c.action = ACT_SEND;
        entry_c.peer   = rank_r + RankW'(1);
        entry_c.bar    = 1'b1;
      end
      PH_FIN_RECV: begin
        entry_c.action = ACT_RECV;
        entry_c.peer   = rank_r - RankW'(1);
        entry_c.bsel   = 1'b1;
        entry_c.bar    = 1'b1;
      end
      PH_FIN_RED: begin
        entry_c.action = ACT_REDUCE;
        entry_c.bar    = 1'b1;
      end
      PH_RS_RECV: begin
        entry_c.action = ACT_RECV;
        entry_c.peer   = dst_r;
        entry_c.bsel   = 1'b1;
        off_idx        = recv_r;
        cnt_a          = ra_r;
        cnt_b          = rb_r;
      end
      PH_RS_SEND: begin
        entry_c.action = ACT_SEND;
        entry_c.peer   = dst_r;
        entry_c.bar    = 1'b1;
        off_idx        = send_r;
        cnt_a          = sa_r;
        cnt_b          = sb_r;
      end
      PH_RS_RED: begin
        entry_c.action = ACT_REDUCE;
        entry_c.bar    = 1'b1;
        off_idx        = recv_r;
        cnt_a          = ra_r;
        cnt_b          = rb_r;
      end
      PH_AG_RECV: begin
        entry_c.action = ACT_RECV;
        entry_c.peer   = dst_r;
        off_idx        = recv_r;
        cnt_a          = ra_r;
        cnt_b          = rb_r;
      end
      PH_AG_SEND: begin
        entry_c.action = ACT_SEND;
        entry_c.peer   = dst_r;
        entry_c.bar    = 1'b1;
        off_idx        = send_r;
        cnt_a          = sa_r;
        cnt_b          = sb_r;
      end
      PH_FOUT: begin
        entry_c.action = rank_r[0] ? ACT_SEND : ACT_RECV;
        entry_c.peer   = rank_r[0] ? (rank_r - RankW'(1)) : (rank_r + RankW'(1));
      end
      PH_DONE: begin
        entry_c.last = 1'b1;
        cnt_b        = '0;
      end
      default: begin
        entry_c.last = 1'b1;
      end
    endcase
  end

  assign is_last = (phase_r == PH_ERR) || (phase_r == PH_DONE);

  // --- phase order ---
  always_comb begin
    case (phase_r)
      PH_COPY:     phase_nx = after_copy(fold_r, rank_r[0], active_r, lg_r);
      PH_FIN_SEND: phase_nx = PH_FOUT;
      PH_FIN_RECV: phase_nx = PH_FIN_RED;
      PH_FIN_RED:  phase_nx = core_start(active_r, lg_r, fold_r);
      PH_RS_RECV:  phase_nx = PH_RS_SEND;
      PH_RS_SEND:  phase_nx = PH_RS_RED;
      PH_RS_RED:   phase_nx = rs_more ? PH_RS_RECV : PH_AG_RECV;
      PH_AG_RECV:  phase_nx = PH_AG_SEND;
      PH_AG_SEND:  phase_nx = (k_r != '0) ? PH_AG_RECV : (fold_r ? PH_FOUT : PH_DONE);
      PH_FOUT:     phase_nx = PH_DONE;
      default:     phase_nx = PH_DONE;
    endcase
  end

  // --- sequencer ---
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    ctl.unit_en    = 1'b0;
    ctl.entry_done = 1'b0;
    ctl.entry      = entry_c;
    mul_op.mult    = off_idx;
    mul_op.add_rem = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_PLAN;
      ST_PLAN: begin
        state_nxt = (plan_phase == PH_RS_RECV) ? ST_STEP : ST_OFF;
      end
      ST_STEP: state_nxt = ST_OFF;
      ST_OFF: begin
        ctl.unit_en = advance;
        if (advance) state_nxt = ST_CNT;
      end
      ST_CNT: begin
        mul_op.mult    = (cnt_b > cnt_a) ? (cnt_b - cnt_a) : '0;
        mul_op.add_rem = (cnt_b > cnt_a) && (cnt_b >= pof2_r);
        ctl.unit_en    = advance;
        ctl.entry_done = advance;
        if (advance) begin
          if (is_last)                         state_nxt = ST_IDLE;
          else if (phase_nx == PH_RS_RECV ||
                   phase_nx == PH_AG_RECV)     state_nxt = ST_STEP;
          else                                 state_nxt = ST_OFF;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_DONE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_PLAN)  phase_r <= plan_phase;
      else if (ctl.entry_done) phase_r <= phase_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cnt_r   <= elem_total;
      inpl_r  <= in_place;
      dtype_r <= dtype_id;
      op_r    <= op_id;
    end
    if (state_r == ST_SETUP) begin
      lg_r   <= lg_c;
      pof2_r <= pof2_c;
      rank_r <= rank_c;
      rem_r  <= rem_c;
    end
    if (state_r == ST_PLAN) begin
      fold_r    <= fold_c;
      active_r  <= active_c;
      newrank_r <= newrank_c;
      q_r       <= cnt_r >> lg_r;
      r_r       <= cnt_r & ~({DataW{1'b1}} << lg_r);
      k_r       <= '0;
      send_r    <= '0;
      recv_r    <= '0;
      last_r    <= pof2_r;
    end
    if (state_r == ST_STEP) begin
      dst_r <= dst_c;
      if (phase_r == PH_AG_RECV) begin
        if (up_c) begin
          last_r <= last_ag;
          recv_r <= send_h;
          sa_r   <= send_r;
          sb_r   <= send_h;
          ra_r   <= send_h;
          rb_r   <= last_ag;
        end else begin
          recv_r <= send_m;
          sa_r   <= send_r;
          sb_r   <= last_r;
          ra_r   <= send_m;
          rb_r   <= send_r;
        end
      end else begin
        if (up_c) begin
          send_r <= recv_h;
          sa_r   <= recv_h;
          sb_r   <= last_r;
          ra_r   <= recv_r;
          rb_r   <= recv_h;
        end else begin
          recv_r <= send_h;
          sa_r   <= send_r;
          sb_r   <= send_h;
          ra_r   <= send_h;
          rb_r   <= last_r;
        end
      end
    end
    if (ctl.entry_done && phase_r == PH_RS_RED) begin
      send_r <= recv_r;
      if (rs_more) begin
        last_r <= recv_r + half_c;
        k_r    <= k_r + StepW'(1);
      end
    end
    if (ctl.entry_done && phase_r == PH_AG_SEND) begin
      if (!up_c)      send_r <= recv_r;
      if (k_r != '0)  k_r <= k_r - StepW'(1);
    end
  end

  assign blk_q = q_r;
  assign blk_r = r_r;

endmodule

// File: rtl/core/allreduce_schedule_generator.sv
// The first entry goes through the setup and plan states, the step state for an exchange, the
// offset and count passes through the shared multiply-add unit, and the pending register.
// Every entry makes both passes, every exchange step a step state; up to 52 entries a request.
// One request is in work at a time; the next is taken once the done entry has been formed.
// Reset (rst_n low at a clock edge): sequencer idle, no entry pending, output empty,
// group_size back to 1 and my_rank to 0.
module allreduce_schedule_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ars_pkg::DataW-1:0]  in_elem_total,
  input  logic                       in_in_place,
  input  logic [ars_pkg::CodeW-1:0]  in_dtype_id,
  input  logic [ars_pkg::CodeW-1:0]  in_op_id,
  // schedule entry channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_action,
  output logic [ars_pkg::RankW-1:0]  out_peer,
  output logic                       out_buffer_sel,
  output logic [ars_pkg::DataW-1:0]  out_elem_offset,
  output logic [ars_pkg::DataW-1:0]  out_elem_count,
  output logic [ars_pkg::CodeW-1:0]  out_dtype_out,
  output logic [ars_pkg::CodeW-1:0]  out_op_out,
  output logic                       out_barrier_after,
  output logic                       out_error,
  output logic                       out_last,
  // configuration write port
  input  logic                       cfg_wr_en,
  input  ars_pkg::cfg_reg_t          cfg_index,
  input  logic [ars_pkg::SizeW-1:0]  cfg_wdata
);
  import ars_pkg::*;

  // Configuration registers, to be written only between requests; the block does not enforce this
  logic [SizeW-1:0] group_size_r;
  logic [RankW-1:0] my_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= SizeW'(1);
      my_rank_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GROUP_SIZE: group_size_r <= cfg_wdata;
        CFG_MY_RANK:    my_rank_r    <= cfg_wdata[RankW-1:0];
        default:        group_size_r <= group_size_r;
      endcase
    end
  end

  // The sequencer walks the phases: optional copy, fold-in, the reduce-scatter steps
  // (three entries each), the allgather steps (two each), fold-out and done, or an error entry.
  // Every entry visits the multiply-add unit twice: first for the element offset
  // (block index times block size), then for the element count (number of blocks
  // times block size, plus the remainder when the range reaches the last block).
  seq_ctl_t         ctl;
  mul_op_t          mul_op;
  logic [DataW-1:0] blk_q, blk_r, mul_res;
  logic             advance;

  ars_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .elem_total (in_elem_total),
    .in_place   (in_in_place),
    .dtype_id   (in_dtype_id),
    .op_id      (in_op_id),
    .group_size (group_size_r),
    .my_rank    (my_rank_r),
    .advance    (advance),
    .ctl        (ctl),
    .mul_op     (mul_op),
    .blk_q      (blk_q),
    .blk_r      (blk_r)
  );

  ars_mul u_mul (
    .clk   (clk),
    .en    (ctl.unit_en),
    .op    (mul_op),
    .blk_q (blk_q),
    .blk_r (blk_r),
    .res   (mul_res)
  );

  // Pending entry: once the count pass is issued, the descriptor and the offset
  // are held here, while the count waits in the unit's result register. While this
  // entry cannot move into the output register, hold the sequencer and the unit.
  logic             pend_r;
  entry_t           pend_entry_r;
  logic [DataW-1:0] pend_off_r;
  logic             out_valid_r;
  logic             slot_busy, emit;

  assign slot_busy = out_valid_r && !out_ready;
  assign emit      = pend_r && !slot_busy;
  assign advance   = !(pend_r && slot_busy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (ctl.entry_done) begin
      pend_r <= 1'b1;
    end else if (emit) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.entry_done) begin
      pend_entry_r <= ctl.entry;
      pend_off_r   <= mul_res;
    end
  end

  // Output register: refill it in the cycle that the previous item leaves,
  // so a pending entry moves in without waiting for the register to be empty.
  entry_t           out_entry_r;
  logic [DataW-1:0] out_off_r, out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_entry_r <= pend_entry_r;
      out_off_r   <= pend_off_r;
      out_cnt_r   <= mul_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_entry_r.action;
  assign out_peer          = out_entry_r.peer;
  assign out_buffer_sel    = out_entry_r.bsel;
  assign out_elem_offset   = out_off_r;
  assign out_elem_count    = out_cnt_r;
  assign out_dtype_out     = out_entry_r.dtype;
  assign out_op_out        = out_entry_r.op;
  assign out_barrier_after = out_entry_r.bar;
  assign out_error         = out_entry_r.err;
  assign out_last          = out_entry_r.last;

endmodule

// File: tb/allreduce_schedule_generator_tb.sv
module allreduce_schedule_generator_tb;
  import ars_pkg::*;

  // One schedule entry as it should leave the block
  typedef struct {
    action_t          action;
    logic [RankW-1:0] peer;
    logic             bsel;
    logic [DataW-1:0] offset;
    logic [DataW-1:0] count;
    logic [CodeW-1:0] dtype;
    logic [CodeW-1:0] op;
    logic             barrier;
    logic             err;
    logic             last;
  } sched_entry_t;

  // One allreduce request waiting to be offered
  typedef struct {
    logic [DataW-1:0] elem_total;
    logic             in_place;
    logic [CodeW-1:0] dtype;
    logic [CodeW-1:0] op;
    bit               wait_drain;  // hold it back until the schedule queue is empty
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [DataW-1:0] in_elem_total = '0;
  logic             in_in_place = 1'b0;
  logic [CodeW-1:0] in_dtype_id = '0;
  logic [CodeW-1:0] in_op_id = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       out_action;
  logic [RankW-1:0] out_peer;
  logic             out_buffer_sel;
  logic [DataW-1:0] out_elem_offset;
  logic [DataW-1:0] out_elem_count;
  logic [CodeW-1:0] out_dtype_out;
  logic [CodeW-1:0] out_op_out;
  logic             out_barrier_after;
  logic             out_error;
  logic             out_last;

  logic             cfg_wr_en = 1'b0;
  cfg_reg_t         cfg_index = CFG_GROUP_SIZE;
  logic [SizeW-1:0] cfg_wdata = '0;

  allreduce_schedule_generator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_elem_total     (in_elem_total),
    .in_in_place       (in_in_place),
    .in_dtype_id       (in_dtype_id),
    .in_op_id          (in_op_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_peer          (out_peer),
    .out_buffer_sel    (out_buffer_sel),
    .out_elem_offset   (out_elem_offset),
    .out_elem_count    (out_elem_count),
    .out_dtype_out     (out_dtype_out),
    .out_op_out        (out_op_out),
    .out_barrier_after (out_barrier_after),
    .out_error         (out_error),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Requests not yet offered, and entries predicted but not yet seen
  request_t     req_q[$];
  sched_entry_t sched_q[$];

  int sent_n = 0;   // requests put on the input port
  int taken_n = 0;  // requests accepted by the block
  int err_cnt = 0;

  int tx_idle_pct = 10;
  int rx_idle_pct = 71;

  // Shadow copy of the configuration registers, as written
  logic [SizeW-1:0] group_size_m = 11'd1;
  logic [RankW-1:0] my_rank_m = '0;

  // Working values of the request being planned
  longint unsigned  blk_quot;
  longint unsigned  blk_rem;
  int unsigned      blk_pof2;
  logic [CodeW-1:0] plan_dtype;
  logic [CodeW-1:0] plan_op;

  // Group size as the block uses it: zero counts as one, large sizes saturate
  function automatic int unsigned eff_size(input logic [SizeW-1:0] raw);
    int unsigned s;
    s = 32'(raw);
    if (s == 0) s = 1;
    if (s > MaxRanks) s = MaxRanks;
    return s;
  endfunction

  function automatic int unsigned pof2_of(input int unsigned size);
    int unsigned p;
    p = 1;
    while (p * 2 <= size) p = p * 2;
    return p;
  endfunction

  // Elements held in blocks [a, b); the last block carries the remainder
  function automatic logic [DataW-1:0] blk_sum(input int unsigned a, input int unsigned b);
    longint unsigned s;
    if (b <= a) return '0;
    s = longint'(b - a) * blk_quot;
    if (b >= blk_pof2) s = s + blk_rem;
    return s[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] blk_off(input int unsigned i);
    longint unsigned s;
    s = longint'(i) * blk_quot;
    return s[DataW-1:0];
  endfunction

  function automatic void push_entry(input action_t act, input int unsigned peer,
                                     input logic bsel, input logic [DataW-1:0] offset,
                                     input logic [DataW-1:0] count, input logic bar,
                                     input logic err, input logic last);
    sched_entry_t e;
    e.action  = act;
    e.peer    = peer[RankW-1:0];
    e.bsel    = bsel;
    e.offset  = offset;
    e.count   = count;
    e.dtype   = plan_dtype;
    e.op      = plan_op;
    e.barrier = bar;
    e.err     = err;
    e.last    = last;
    sched_q.push_back(e);
  endfunction

  // Work out this node's whole schedule for one request and queue its entries
  function automatic void plan_schedule(input logic [DataW-1:0] count, input logic inpl,
                                        input logic [CodeW-1:0] dt,
                                        input logic [CodeW-1:0] op);
    int unsigned size, rank, pof2, rem, newrank, mask, newdst, dst;
    int unsigned snd_blk, rcv_blk, end_blk;
    logic [DataW-1:0] scnt, rcnt;
    bit active;

    plan_dtype = dt;
    plan_op = op;
    size = eff_size(group_size_m);
    rank = 32'(my_rank_m);
    if (rank >= size) rank = size - 1;
    pof2 = pof2_of(size);
    rem = size - pof2;
    blk_pof2 = pof2;

    // Too few elements to give every power-of-two rank a block
    if (count < pof2) begin
      push_entry(ACT_DONE, 0, 1'b0, '0, '0, 1'b0, 1'b1, 1'b1);
      return;
    end
    blk_quot = 64'(count) / 64'(pof2);
    blk_rem = 64'(count) - blk_quot * 64'(pof2);

    if (!inpl) push_entry(ACT_COPY, 0, 1'b0, '0, count, 1'b1, 1'b0, 1'b0);

    // Fold the surplus ranks into their odd neighbours
    active = 1'b1;
    newrank = 0;
    if (rank < 2 * rem) begin
      if (rank % 2 == 0) begin
        push_entry(ACT_SEND, rank + 1, 1'b0, '0, count, 1'b1, 1'b0, 1'b0);
        active = 1'b0;
      end else begin
        push_entry(ACT_RECV, rank - 1, 1'b1, '0, count, 1'b1, 1'b0, 1'b0);
        push_entry(ACT_REDUCE, 0, 1'b0, '0, count, 1'b1, 1'b0, 1'b0);
        newrank = rank / 2;
      end
    end else begin
      newrank = rank - rem;
    end

    if (active) begin
      // Reduce-scatter: halve the owned block range at every step
      mask = 1;
      snd_blk = 0;
      rcv_blk = 0;
      end_blk = pof2;
      while (mask < pof2) begin
        newdst = newrank ^ mask;
        dst = (newdst < rem) ? newdst * 2 + 1 : newdst + rem;
        if (newrank < newdst) begin
          snd_blk = rcv_blk + pof2 / (mask * 2);
          scnt = blk_sum(snd_blk, end_blk);
          rcnt = blk_sum(rcv_blk, snd_blk);
        end else begin
          rcv_blk = snd_blk + pof2 / (mask * 2);
          scnt = blk_sum(snd_blk, rcv_blk);
          rcnt = blk_sum(rcv_blk, end_blk);
        end
        push_entry(ACT_RECV, dst, 1'b1, blk_off(rcv_blk), rcnt, 1'b0, 1'b0, 1'b0);
        push_entry(ACT_SEND, dst, 1'b0, blk_off(snd_blk), scnt, 1'b1, 1'b0, 1'b0);
        push_entry(ACT_REDUCE, 0, 1'b0, blk_off(rcv_blk), rcnt, 1'b1, 1'b0, 1'b0);
        snd_blk = rcv_blk;
        mask = mask << 1;
        if (mask < pof2) end_blk = rcv_blk + pof2 / mask;
      end

      // Allgather: double the range again in the reverse order
      mask = mask >> 1;
      while (mask > 0) begin
        newdst = newrank ^ mask;
        dst = (newdst < rem) ? newdst * 2 + 1 : newdst + rem;
        if (newrank < newdst) begin
          if (mask != pof2 / 2) end_blk = end_blk + pof2 / (mask * 2);
          rcv_blk = snd_blk + pof2 / (mask * 2);
          scnt = blk_sum(snd_blk, rcv_blk);
          rcnt = blk_sum(rcv_blk, end_blk);
        end else begin
          rcv_blk = snd_blk - pof2 / (mask * 2);
          scnt = blk_sum(snd_blk, end_blk);
          rcnt = blk_sum(rcv_blk, snd_blk);
        end
        push_entry(ACT_RECV, dst, 1'b0, blk_off(rcv_blk), rcnt, 1'b0, 1'b0, 1'b0);
        push_entry(ACT_SEND, dst, 1'b0, blk_off(snd_blk), scnt, 1'b1, 1'b0, 1'b0);
        if (newrank > newdst) snd_blk = rcv_blk;
        mask = mask >> 1;
      end
    end

    // Fold-out: hand the result back to the surplus ranks
    if (rank < 2 * rem) begin
      if (rank % 2 == 1) push_entry(ACT_SEND, rank - 1, 1'b0, '0, count, 1'b0, 1'b0, 1'b0);
      else push_entry(ACT_RECV, rank + 1, 1'b0, '0, count, 1'b0, 1'b0, 1'b0);
    end

    push_entry(ACT_DONE, 0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void check_field(input string name, input logic [DataW-1:0] exp_v,
                                      input logic [DataW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  function automatic void queue_req(input logic [DataW-1:0] total, input logic inpl,
                                    input logic [CodeW-1:0] dt, input logic [CodeW-1:0] op,
                                    input bit wait_drain);
    request_t r;
    r.elem_total = total;
    r.in_place   = inpl;
    r.dtype      = dt;
    r.op         = op;
    r.wait_drain = wait_drain;
    req_q.push_back(r);
  endfunction

  // Driver: change inputs on the falling edge only. A new item is offered once
  // the last one has been taken; valid stays high across back-to-back items.
  always @(negedge clk) begin
    request_t r;
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (!in_valid || taken_n == sent_n) begin
      if (req_q.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
          !(req_q[0].wait_drain && sched_q.size() != 0)) begin
        r = req_q.pop_front();
        in_valid      <= 1'b1;
        in_elem_total <= r.elem_total;
        in_in_place   <= r.in_place;
        in_dtype_id   <= r.dtype;
        in_op_id      <= r.op;
        sent_n++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: sample both channels on the rising edge. Check the outgoing entry
  // first, then plan the schedule of any request taken at the same edge, so a
  // fresh request can never stand in for a missing expectation.
  always @(posedge clk) begin
    sched_entry_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (sched_q.size() == 0) begin
          $error("schedule entry with no expectation: action %0d", out_action);
          err_cnt++;
        end else begin
          e = sched_q.pop_front();
          check_field("action", DataW'(e.action), DataW'(out_action));
          check_field("peer", DataW'(e.peer), DataW'(out_peer));
          check_field("buffer_sel", DataW'(e.bsel), DataW'(out_buffer_sel));
          check_field("elem_offset", e.offset, out_elem_offset);
          check_field("elem_count", e.count, out_elem_count);
          check_field("dtype_out", DataW'(e.dtype), DataW'(out_dtype_out));
          check_field("op_out", DataW'(e.op), DataW'(out_op_out));
          check_field("barrier_after", DataW'(e.barrier), DataW'(out_barrier_after));
          check_field("error", DataW'(e.err), DataW'(out_error));
          check_field("last", DataW'(e.last), DataW'(out_last));
        end
      end
      if (in_valid && in_ready) begin
        plan_schedule(in_elem_total, in_in_place, in_dtype_id, in_op_id);
        taken_n++;
      end
    end
  end

  // Write both registers while the block is idle, then update the shadow copy
  task automatic write_cfg(input logic [SizeW-1:0] size_v, input logic [SizeW-1:0] rank_v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_GROUP_SIZE;
    cfg_wdata <= size_v;
    @(negedge clk);
    cfg_index <= CFG_MY_RANK;
    cfg_wdata <= rank_v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    group_size_m = size_v;
    my_rank_m = rank_v[RankW-1:0];
    @(posedge clk);
  endtask

  // Wait until every queued request is taken and every entry has come out,
  // then let the block settle for a little longer than its start-up latency
  task automatic drain();
    while (req_q.size() != 0 || taken_n != sent_n || sched_q.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int unsigned      p, r;
    int               n;
    logic [SizeW-1:0] size_v, rank_v;
    logic [DataW-1:0] total;

    // Hold reset low at the start, release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part; the first batch runs on the values left by reset
    queue_req(32'd0, 1'b0, 8'h00, 8'h00, 1'b0);
    queue_req(32'd1, 1'b1, 8'hFF, 8'hFF, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0, 8'hA5, 8'h5A, 1'b0);
    drain();

    // Full group, top rank: no fold-in, ten exchange steps
    write_cfg(11'd1024, 11'd1023);
    queue_req(32'd1023, 1'b0, 8'h11, 8'h22, 1'b0);
    queue_req(32'd1024, 1'b0, 8'h33, 8'h44, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b1, 8'h55, 8'h66, 1'b0);
    drain();

    // Even surplus rank: folds in by sending and sits out the exchanges
    write_cfg(11'd7, 11'd0);
    queue_req(32'd3, 1'b0, 8'h01, 8'h02, 1'b0);
    queue_req(32'd4, 1'b1, 8'h03, 8'h04, 1'b0);
    queue_req(32'd1000, 1'b0, 8'h05, 8'h06, 1'b0);
    drain();

    // Odd surplus rank: receives, reduces, then takes part
    write_cfg(11'd7, 11'd5);
    queue_req(32'hFFFF_FFFF, 1'b0, 8'h07, 8'h08, 1'b0);
    queue_req(32'd9, 1'b1, 8'h09, 8'h0A, 1'b1);
    drain();

    // Rank above the surplus pairs
    write_cfg(11'd7, 11'd6);
    queue_req(32'd10, 1'b0, 8'h0B, 8'h0C, 1'b0);
    drain();

    // Group size zero counts as one
    write_cfg(11'd0, 11'd0);
    queue_req(32'd5, 1'b0, 8'h0D, 8'h0E, 1'b0);
    drain();

    // Both registers at their widest: size saturates, rank loses its top bit
    write_cfg(11'h7FF, 11'h7FF);
    queue_req(32'd1000000, 1'b0, 8'h0F, 8'h10, 1'b0);
    drain();

    // Largest surplus with an odd rank: it folds in, takes part and folds out
    write_cfg(11'd1023, 11'd1021);
    queue_req(32'hFFFF_FFFF, 1'b0, 8'hF0, 8'h0F, 1'b0);
    queue_req(32'd511, 1'b1, 8'hC3, 8'h3C, 1'b0);
    drain();

    write_cfg(11'd1023, 11'd1022);
    queue_req(32'd12345678, 1'b1, 8'h12, 8'h34, 1'b0);
    drain();

    // Rank not below the group size saturates to the top rank
    write_cfg(11'd5, 11'd9);
    queue_req(32'd7, 1'b0, 8'h56, 8'h78, 1'b0);
    drain();

    write_cfg(11'd2, 11'd1);
    queue_req(32'd2, 1'b0, 8'h9A, 8'hBC, 1'b0);
    queue_req(32'd3, 1'b1, 8'hDE, 8'hF1, 1'b0);
    drain();

    write_cfg(11'd1024, 11'd0);
    queue_req(32'h8000_0000, 1'b0, 8'h80, 8'h01, 1'b0);
    drain();

    write_cfg(11'd3, 11'd2);
    queue_req(32'd2, 1'b0, 8'h7F, 8'hFE, 1'b0);
    drain();

    // Random part: a fresh setting per batch, idling pattern by batch number
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 10;
        rx_idle_pct = 71;
      end else if (ph < 8) begin
        tx_idle_pct = 71;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      // Keep most groups small; large ones make long schedules
      r = $urandom_range(99);
      if (r < 60) size_v = SizeW'($urandom_range(16, 1));
      else if (r < 85) size_v = SizeW'($urandom_range(130, 17));
      else if (r < 95) size_v = SizeW'($urandom_range(1024, 131));
      else size_v = SizeW'($urandom_range(2047, 0));
      if ($urandom_range(99) < 85)
        rank_v = (size_v > 1) ? SizeW'($urandom_range(size_v - 1, 0)) : '0;
      else rank_v = SizeW'($urandom_range(2047, 0));
      write_cfg(size_v, rank_v);

      p = pof2_of(eff_size(group_size_m));
      n = 20 + $urandom_range(6);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99);
        if (r < 30) total = $urandom_range(2 * p + 3, 0);
        else if (r < 60) total = $urandom_range(65535, 0);
        else if (r < 85) total = $urandom;
        else total = 32'hFFFF_FFFF - $urandom_range(p, 0);
        // Let the schedule queue run dry once in every batch, and now and then
        queue_req(total, 1'($urandom_range(1)), CodeW'($urandom_range(255)),
                  CodeW'($urandom_range(255)), (i == 10) || ($urandom_range(39) == 0));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sched_q.size() != 0) begin
      $error("%0d schedule entries never arrived", sched_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
